// ===== rtl/lfc_pkg.sv =====
// Shared types, action codes and register defaults for the line follower turn controller.
`timescale 1ns / 1ps

package lfc_pkg;

    localparam int SPEED_W = 7;
    localparam int HOLD_W  = 6;
    localparam int DRIVE_W = 8;
    localparam int ACT_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SPEED_W;

    localparam logic [ACT_W-1:0] ACT_HOLD    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FORWARD = 3'd1;
    localparam logic [ACT_W-1:0] ACT_NUDGE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LEFT    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RIGHT   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_STOP    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPEED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_SPEED      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_HOLD_TICKS = 2'd2;

    localparam logic [SPEED_W-1:0] DRIVE_SPEED_RST     = 7'd70;
    localparam logic [SPEED_W-1:0] TURN_SPEED_RST      = 7'd85;
    localparam logic [HOLD_W-1:0]  TURN_HOLD_TICKS_RST = 6'd10;
    localparam logic [HOLD_W-1:0]  HOLD_MAX            = 6'd63;

    typedef struct packed {
        logic sense_left;
        logic sense_right;
        logic sense_mid_left;
        logic sense_mid_right;
    } sense_t;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic                      left_indicator;
        logic                      right_indicator;
    } motor_t;

    // One side's armed turn state.
    typedef struct packed {
        logic              armed;
        logic [HOLD_W-1:0] count;
        logic              flash;
    } side_t;

endpackage

// ===== rtl/line_follower_turn_controller.sv =====
// Line follower turn controller: sensor word in, motor command word out.
// A command word is on out_data with out_valid once it has passed the input register and then the result register.
// Throughput: one word per cycle unless out_ready stalls the result register; an input register and
// a result register stand between the two handshakes, and the whole decision is one pass between them.
// Reset: rst_n clears all turn, realign, hold and flash state and loads the
// default speeds (70, 85) and hold threshold (10); no words are in flight after reset.
`timescale 1ns / 1ps

module line_follower_turn_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  lfc_pkg::sense_t                in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output lfc_pkg::motor_t                out_data,
    input  logic                           cfg_write,
    input  logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lfc_pkg::*;

    logic [SPEED_W-1:0] drive_speed_reg;
    logic [SPEED_W-1:0] turn_speed_reg;
    logic [HOLD_W-1:0]  turn_hold_ticks_reg;

    logic   in_valid_reg;
    sense_t in_reg;
    logic   out_valid_reg;
    motor_t out_reg;
    motor_t out_next;

    side_t left_reg, right_reg, left_next, right_next;
    side_t left_mid, right_mid;
    logic  realign_left_reg, realign_right_reg, realign_count_reg;
    logic  realign_left_next, realign_right_next, realign_count_next;
    logic  realign_left_mid, realign_right_mid;

    logic             advance;
    logic             stop;
    logic             any_armed;
    logic [ACT_W-1:0] act;
    logic signed [DRIVE_W-1:0] drive_fwd, turn_pos, turn_neg;

    // While armed, bump the hold count; release once past the threshold with the middle sensor on the line.
    function automatic side_t hold_update(side_t s, logic mid, logic [HOLD_W-1:0] thresh);
        side_t r;
        r = s;
        if (s.armed)
        begin
            r.flash = 1'b1;
            if (s.count < HOLD_MAX)
            begin
                r.count = s.count + HOLD_W'(1);
            end
            if (r.count > thresh && mid)
            begin
                r.count = '0;
                r.armed = 1'b0;
                r.flash = 1'b0;
            end
        end
        return r;
    endfunction

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign drive_fwd = DRIVE_W'(-$signed({1'b0, drive_speed_reg}));
    assign turn_pos  = $signed({1'b0, turn_speed_reg});
    assign turn_neg  = DRIVE_W'(-$signed({1'b0, turn_speed_reg}));

    always_comb
    begin
        stop      = in_reg.sense_left && in_reg.sense_right
                    && in_reg.sense_mid_left && in_reg.sense_mid_right;
        any_armed = left_reg.armed || right_reg.armed;

        left_mid          = left_reg;
        right_mid         = right_reg;
        realign_left_mid  = realign_left_reg;
        realign_right_mid = realign_right_reg;
        act               = ACT_FORWARD;

        priority if (left_reg.armed && !right_reg.armed)
        begin
            act = ACT_LEFT;
        end
        else if (right_reg.armed && !left_reg.armed)
        begin
            act = ACT_RIGHT;
        end
        else if (in_reg.sense_left && !any_armed)
        begin
            act             = ACT_NUDGE;
            left_mid.armed  = 1'b1;
            right_mid.armed = 1'b0;
        end
        else if (in_reg.sense_right && !any_armed)
        begin
            act             = ACT_NUDGE;
            left_mid.armed  = 1'b0;
            right_mid.armed = 1'b1;
        end
        else if (realign_left_reg)
        begin
            act = ACT_LEFT;
        end
        else if (realign_right_reg)
        begin
            act = ACT_RIGHT;
        end
        else if (in_reg.sense_mid_left)
        begin
            act              = ACT_HOLD;
            realign_left_mid = 1'b1;
        end
        else if (in_reg.sense_mid_right)
        begin
            act               = ACT_HOLD;
            realign_right_mid = 1'b1;
        end
        else
        begin
            act = ACT_FORWARD;
        end

        // Realign timer
        realign_left_next  = realign_left_mid;
        realign_right_next = realign_right_mid;
        realign_count_next = realign_count_reg;
        if (realign_left_mid || realign_right_mid)
        begin
            if (realign_count_reg)
            begin
                realign_count_next = 1'b0;
                realign_left_next  = 1'b0;
                realign_right_next = 1'b0;
            end
            else
            begin
                realign_count_next = 1'b1;
            end
        end

        left_next  = hold_update(left_mid, in_reg.sense_mid_left, turn_hold_ticks_reg);
        right_next = hold_update(right_mid, in_reg.sense_mid_right, turn_hold_ticks_reg);

        out_next.action          = act;
        out_next.left_indicator  = left_next.flash;
        out_next.right_indicator = right_next.flash;
        unique case (act)
            ACT_FORWARD, ACT_NUDGE:
            begin
                out_next.left_drive  = drive_fwd;
                out_next.right_drive = drive_fwd;
            end
            ACT_LEFT:
            begin
                out_next.left_drive  = turn_pos;
                out_next.right_drive = turn_neg;
            end
            ACT_RIGHT:
            begin
                out_next.left_drive  = turn_neg;
                out_next.right_drive = turn_pos;
            end
            default:
            begin
                out_next.left_drive  = '0;
                out_next.right_drive = '0;
            end
        endcase

        // All four on the line: stop, keep state
        if (stop)
        begin
            out_next.action          = ACT_STOP;
            out_next.left_drive      = '0;
            out_next.right_drive     = '0;
            out_next.left_indicator  = left_reg.flash;
            out_next.right_indicator = right_reg.flash;
            left_next          = left_reg;
            right_next         = right_reg;
            realign_left_next  = realign_left_reg;
            realign_right_next = realign_right_reg;
            realign_count_next = realign_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_speed_reg     <= DRIVE_SPEED_RST;
            turn_speed_reg      <= TURN_SPEED_RST;
            turn_hold_ticks_reg <= TURN_HOLD_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DRIVE_SPEED:     drive_speed_reg     <= cfg_data;
                CFG_TURN_SPEED:      turn_speed_reg      <= cfg_data;
                CFG_TURN_HOLD_TICKS: turn_hold_ticks_reg <= cfg_data[HOLD_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            left_reg          <= '0;
            right_reg         <= '0;
            realign_left_reg  <= 1'b0;
            realign_right_reg <= 1'b0;
            realign_count_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg     <= 1'b1;
                left_reg          <= left_next;
                right_reg         <= right_next;
                realign_left_reg  <= realign_left_next;
                realign_right_reg <= realign_right_next;
                realign_count_reg <= realign_count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_single_arm: assert property (@(posedge clk) disable iff (!rst_n)
        !(left_reg.armed && right_reg.armed))
        else $error("both turns armed");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!left_reg.armed -> left_reg.count == '0)
        && (!right_reg.armed -> right_reg.count == '0))
        else $error("hold count running while not armed");

    a_flash_arm: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg.flash == left_reg.armed && right_reg.flash == right_reg.armed)
        else $error("indicator out of step with armed turn");

    a_realign_timer: assert property (@(posedge clk) disable iff (!rst_n)
        realign_count_reg |-> (realign_left_reg || realign_right_reg))
        else $error("realign timer running with no realign flag");

endmodule

// ===== verif/line_follower_turn_controller_tb.sv =====
// Self-checking testbench for the line follower turn controller: sensor words in, commands checked.
`timescale 1ns / 1ps

module line_follower_turn_controller_tb;

    import lfc_pkg::*;

    localparam int PHASE_WORDS = 125;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    sense_t                in_data;
    logic                  out_valid;
    logic                  out_ready;
    motor_t                out_data;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    line_follower_turn_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and the steering state
    logic [SPEED_W-1:0] drive_speed_q;
    logic [SPEED_W-1:0] turn_speed_q;
    logic [HOLD_W-1:0]  hold_ticks_q;
    side_t              left_side;
    side_t              right_side;
    logic               realign_l;
    logic               realign_r;
    logic               realign_cnt;

    sense_t sense_queue[$];
    motor_t expected_cmds[$];

    int   words_queued  = 0;
    int   words_sent    = 0;
    int   words_checked = 0;
    int   mismatches    = 0;
    int   settings_used = 1;
    int   cycle_no      = 0;
    int   action_seen[6];
    logic in_taken      = 1'b0;
    logic calm;

    // Long stretches with no idling on either side
    assign calm = ((cycle_no / 400) % 3) == 2;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic side_t side_after(side_t sd, logic mid, logic [HOLD_W-1:0] ticks);
        side_t nx;
        nx = sd;
        if (sd.armed)
        begin
            nx.flash = 1'b1;
            if (nx.count != HOLD_MAX)
                nx.count = nx.count + HOLD_W'(1);
            // release: count, armed and flash all drop
            if (nx.count > ticks && mid)
                nx = '0;
        end
        return nx;
    endfunction

    // Work out the command for one sensor word and advance the steering state
    function automatic motor_t steer(sense_t s);
        motor_t                    m;
        logic [ACT_W-1:0]          act;
        logic signed [DRIVE_W-1:0] cruise;
        logic signed [DRIVE_W-1:0] spin;
        logic                      any_armed;
        m = '0;
        cruise = -$signed({1'b0, drive_speed_q});
        spin = $signed({1'b0, turn_speed_q});
        any_armed = left_side.armed || right_side.armed;
        if (&s)
        begin
            m.action = ACT_STOP;
            m.left_indicator = left_side.flash;
            m.right_indicator = right_side.flash;
            return m;
        end
        if (left_side.armed && !right_side.armed)
            act = ACT_LEFT;
        else if (right_side.armed && !left_side.armed)
            act = ACT_RIGHT;
        else if (s.sense_left && !any_armed)
        begin
            act = ACT_NUDGE;
            right_side.armed = 1'b0;
            left_side.armed = 1'b1;
        end
        else if (s.sense_right && !any_armed)
        begin
            act = ACT_NUDGE;
            left_side.armed = 1'b0;
            right_side.armed = 1'b1;
        end
        else if (realign_l)
            act = ACT_LEFT;
        else if (realign_r)
            act = ACT_RIGHT;
        else if (s.sense_mid_left)
        begin
            act = ACT_HOLD;
            realign_l = 1'b1;
        end
        else if (s.sense_mid_right)
        begin
            act = ACT_HOLD;
            realign_r = 1'b1;
        end
        else
            act = ACT_FORWARD;

        m.action = act;
        case (act)
            ACT_FORWARD, ACT_NUDGE:
            begin
                m.left_drive = cruise;
                m.right_drive = cruise;
            end
            ACT_LEFT:
            begin
                m.left_drive = spin;
                m.right_drive = -spin;
            end
            ACT_RIGHT:
            begin
                m.left_drive = -spin;
                m.right_drive = spin;
            end
            default:
            begin
                m.left_drive = '0;
                m.right_drive = '0;
            end
        endcase

        // realign timer
        if (realign_l || realign_r)
        begin
            if (realign_cnt)
            begin
                realign_cnt = 1'b0;
                realign_l = 1'b0;
                realign_r = 1'b0;
            end
            else
                realign_cnt = 1'b1;
        end

        left_side = side_after(left_side, s.sense_mid_left, hold_ticks_q);
        right_side = side_after(right_side, s.sense_mid_right, hold_ticks_q);
        m.left_indicator = left_side.flash;
        m.right_indicator = right_side.flash;
        return m;
    endfunction

    function automatic sense_t pick_sense();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return sense_t'(4'b1111);
        else if (roll < 50)
            return sense_t'({2'b00, 2'($urandom_range(3))});
        else
            return sense_t'(4'($urandom_range(15)));
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Bits are {left, right, mid_left, mid_right}
    task automatic queue_sense(logic [3:0] bits);
        sense_queue.push_back(sense_t'(bits));
        words_queued++;
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (words_checked != words_queued);
        // let the pipeline drain before touching registers
        repeat (4) @(negedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_DRIVE_SPEED:     drive_speed_q = val;
            CFG_TURN_SPEED:      turn_speed_q = val;
            CFG_TURN_HOLD_TICKS: hold_ticks_q = val[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(int ds, int ts, int ht);
        put_reg(CFG_DRIVE_SPEED, CFG_DATA_W'(ds));
        put_reg(CFG_TURN_SPEED, CFG_DATA_W'(ts));
        put_reg(CFG_TURN_HOLD_TICKS, CFG_DATA_W'(ht));
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Sensor word driver and ready generator
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (!in_valid || in_taken)
            begin
                if (sense_queue.size() != 0 && (calm || $urandom_range(99) >= 10))
                begin
                    in_data <= sense_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    // Monitor: predict on accept, compare on result
    always @(posedge clk)
    begin
        motor_t want;
        if (rst_n)
        begin
            cycle_no <= cycle_no + 1;
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                expected_cmds.push_back(steer(in_data));
                words_sent++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $error("command word with none expected: action %0d", out_data.action);
                    mismatches++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    check_field("action", want.action, out_data.action);
                    check_field("left_drive", want.left_drive, out_data.left_drive);
                    check_field("right_drive", want.right_drive, out_data.right_drive);
                    check_field("left_indicator", want.left_indicator,
                                out_data.left_indicator);
                    check_field("right_indicator", want.right_indicator,
                                out_data.right_indicator);
                    if (want.action <= ACT_STOP)
                        action_seen[want.action]++;
                    words_checked++;
                end
            end
        end
    end

    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        drive_speed_q = DRIVE_SPEED_RST;
        turn_speed_q = TURN_SPEED_RST;
        hold_ticks_q = TURN_HOLD_TICKS_RST;
        left_side = '0;
        right_side = '0;
        realign_l = 1'b0;
        realign_r = 1'b0;
        realign_cnt = 1'b0;
        foreach (action_seen[i])
            action_seen[i] = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed pass at the reset settings
        queue_sense(4'b0000);
        queue_sense(4'b1111);
        queue_sense(4'b0011);   // both mids: left realign wins
        queue_sense(4'b0000);   // realign left turn, timer clears flags
        queue_sense(4'b0001);
        queue_sense(4'b0000);
        queue_sense(4'b1100);   // both outer: nudge and arm left
        repeat (9) queue_sense(4'b0000);
        queue_sense(4'b1111);   // stop keeps the flash
        queue_sense(4'b0010);   // hold count now past threshold: release
        queue_sense(4'b0100);   // nudge and arm right
        queue_sense(4'b0001);   // too early to release
        queue_sense(4'b1111);
        settle();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: program_regs(0, 0, 0);
                1: program_regs(100, 100, 63);
                2: program_regs(100, 100, 62);
                5: program_regs(1, 100, 1);
                default: program_regs($urandom_range(100), $urandom_range(100),
                                      $urandom_range(62));
            endcase
            repeat (PHASE_WORDS) queue_sense(pick_sense());
            settle();
        end

        if (expected_cmds.size() != 0)
        begin
            $error("%0d command words never arrived", expected_cmds.size());
            mismatches++;
        end
        $display("Checked %0d command words for %0d sensor words over %0d register settings",
                 words_checked, words_sent, settings_used);
        $display("Actions seen: hold %0d forward %0d nudge %0d left %0d right %0d stop %0d",
                 action_seen[ACT_HOLD], action_seen[ACT_FORWARD], action_seen[ACT_NUDGE],
                 action_seen[ACT_LEFT], action_seen[ACT_RIGHT], action_seen[ACT_STOP]);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lfc_pkg.sv
rtl/line_follower_turn_controller.sv
verif/line_follower_turn_controller_tb.sv
